@@ hdl/neural_activation_unit_defines.svh @@
// Assertion macros shared by the activation unit.
`ifndef NEURAL_ACTIVATION_UNIT_DEFINES_SVH
`define NEURAL_ACTIVATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define NAU_CHECK(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NAU_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/nau_pkg.sv @@
package nau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int Q_ONE      = 1 << FRAC_BITS;
   localparam int NSTAGE     = 10;

   // Sigmoid segment bounds and rounded offsets.
   localparam int SIG_SAT = 5 * Q_ONE;
   localparam int SIG_K2  = (19 * Q_ONE) / 8;
   localparam int SIG_B2  = 27 * Q_ONE + 16;
   localparam int SIG_B1  = 5 * Q_ONE + 4;
   localparam int SIG_B0  = 2 * Q_ONE + 2;

   localparam logic [15:0] C_16  = 16'd52290;
   localparam logic [15:0] K_16  = 16'd2930;
   localparam logic [15:0] K3_16 = 16'd8791;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [17:0] sm_type;
   typedef logic signed [18:0] sg_type;
   typedef logic signed [19:0] mca_type;
   typedef logic signed [20:0] mc_type;
   typedef logic signed [24:0] opa_type;
   typedef logic signed [34:0] acc_type;

   typedef enum logic [2:0] {
      KIND_GELU   = 3'd0,
      KIND_RELU   = 3'd1,
      KIND_SILU   = 3'd2,
      KIND_MISH   = 3'd3,
      KIND_SWIGLU = 3'd4
   } kind_type;

   typedef enum logic {
      MODE_FWD = 1'b0,
      MODE_BWD = 1'b1
   } mode_type;

   typedef struct packed {
      kind_type kind;
      mode_type mode;
   } ctl_type;

   typedef struct packed {
      acc_type fwd;
      acc_type bwd;
   } gelu_res_type;

   typedef struct packed {
      acc_type relu_f;
      acc_type relu_b;
      acc_type silu_f;
      acc_type silu_b;
      acc_type mish_f;
      acc_type mish_b;
   } smooth_res_type;

   typedef struct packed {
      acc_type fwd;
      acc_type bwd_main;
      acc_type bwd_gate;
   } swiglu_res_type;

   // Fixed-point product, rounded half up back to the value's scale.
   function automatic acc_type mulq(opa_type a, sm_type b);
      logic signed [42:0] p;
      p = 43'(a) * 43'(b) + 43'sd128;
      return $signed(p[42:8]);
   endfunction

   // Product with a Q16 constant, rounded half up.
   function automatic mc_type mulc(mca_type a, logic [15:0] k);
      logic signed [36:0] p;
      p = 37'(a) * $signed({21'd0, k}) + 37'sd32768;
      return $signed(p[36:16]);
   endfunction

   // Piecewise-linear sigmoid, mirrored for negative inputs.
   function automatic sm_type sig(sg_type x);
      logic [18:0] a;
      logic [18:0] y;
      a = x[18] ? 19'(-x) : 19'(x);
      if (a >= 19'(SIG_SAT)) begin
         y = 19'(Q_ONE);
      end else if (a >= 19'(SIG_K2)) begin
         y = (a + 19'(SIG_B2)) >> 5;
      end else if (a >= 19'(Q_ONE)) begin
         y = (a + 19'(SIG_B1)) >> 3;
      end else begin
         y = (a + 19'(SIG_B0)) >> 2;
      end
      return x[18] ? sm_type'(Q_ONE) - sm_type'(y) : sm_type'(y);
   endfunction

   function automatic sm_type th(sm_type x);
      sg_type x2;
      sm_type s;
      x2 = $signed({x, 1'b0});
      s  = sig(x2);
      return (s <<< 1) - sm_type'(Q_ONE);
   endfunction

   // Knots of log1p(exp(-a)) at integer a, Q16.
   function automatic logic [15:0] lp_tab(logic [3:0] idx);
      logic [15:0] r;
      case (idx)
         4'd0:    r = 16'd45426;
         4'd1:    r = 16'd20530;
         4'd2:    r = 16'd8318;
         4'd3:    r = 16'd3184;
         4'd4:    r = 16'd1189;
         4'd5:    r = 16'd440;
         4'd6:    r = 16'd162;
         4'd7:    r = 16'd60;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   // Interpolated log1p(exp(-a)) for a magnitude a; zero from 8.0 up.
   function automatic sm_type lp(logic [15:0] a);
      logic [3:0]  idx;
      logic [8:0]  f;
      logic [25:0] s;
      idx = {1'b0, a[10:8]};
      f   = {1'b0, a[7:0]};
      s   = 26'(lp_tab(idx)) * 26'(9'(Q_ONE) - f)
          + 26'(lp_tab(idx + 4'd1)) * 26'(f) + 26'd32768;
      return (a[15:11] != 5'd0) ? sm_type'(0) : sm_type'(s[25:16]);
   endfunction

endpackage

@@ hdl/nau_gelu.sv @@
module nau_gelu (
   input  logic                   clock,
   input  logic                   en,
   input  nau_pkg::data_type      value_in,
   input  nau_pkg::data_type      upstream_grad,
   output nau_pkg::gelu_res_type  res
);
   import nau_pkg::*;

   localparam data_type VC_MAX = data_type'(8 * Q_ONE);
   localparam data_type VC_MIN = data_type'(-8 * Q_ONE);

   data_type v_ff  [1:6];
   data_type dy_ff [1:9];
   data_type vc_ff [1:7];
   sm_type   du_ff [4:8];
   sm_type   t_ff  [6:9];
   sm_type   fr_ff [8:NSTAGE];
   sm_type   v2_ff, k3_ff, mc1_ff, u_ff, f_ff, tt_ff, a_ff, b_ff;
   mca_type  p3_ff;
   acc_type  bwd_ff;
   data_type vc_in;
   sm_type   d_in;

   always_comb begin
      if (value_in > VC_MAX) begin
         vc_in = VC_MAX;
      end else if (value_in < VC_MIN) begin
         vc_in = VC_MIN;
      end else begin
         vc_in = value_in;
      end
      d_in = (sm_type'(Q_ONE) + t_ff[9] + b_ff + sm_type'(1)) >>> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[1]  <= value_in;
         dy_ff[1] <= upstream_grad;
         vc_ff[1] <= vc_in;
         for (int k = 2; k <= 6; k++) v_ff[k] <= v_ff[k-1];
         for (int k = 2; k <= 9; k++) dy_ff[k] <= dy_ff[k-1];
         for (int k = 2; k <= 7; k++) vc_ff[k] <= vc_ff[k-1];
         for (int k = 5; k <= 8; k++) du_ff[k] <= du_ff[k-1];
         for (int k = 7; k <= 9; k++) t_ff[k] <= t_ff[k-1];
         for (int k = 9; k <= NSTAGE; k++) fr_ff[k] <= fr_ff[k-1];
         v2_ff    <= sm_type'(mulq(opa_type'(vc_ff[1]), sm_type'(vc_ff[1])));
         p3_ff    <= mca_type'(mulq(opa_type'(v2_ff), sm_type'(vc_ff[2])));
         k3_ff    <= sm_type'(mulc(mca_type'(v2_ff), K3_16));
         mc1_ff   <= sm_type'(mulc(p3_ff, K_16));
         du_ff[4] <= sm_type'(mulc(mca_type'(k3_ff) + mca_type'(Q_ONE), C_16));
         u_ff     <= sm_type'(mulc(mca_type'(vc_ff[4]) + mca_type'(mc1_ff), C_16));
         t_ff[6]  <= th(u_ff);
         f_ff     <= sm_type'(mulq(opa_type'(v_ff[6]), t_ff[6] + sm_type'(Q_ONE)));
         tt_ff    <= sm_type'(mulq(opa_type'(t_ff[6]), t_ff[6]));
         a_ff     <= sm_type'(mulq(opa_type'(vc_ff[7]), sm_type'(Q_ONE) - tt_ff));
         fr_ff[8] <= (f_ff + sm_type'(1)) >>> 1;
         b_ff     <= sm_type'(mulq(opa_type'(a_ff), du_ff[8]));
         bwd_ff   <= mulq(opa_type'(dy_ff[9]), d_in);
      end
   end

   assign res.fwd = acc_type'(fr_ff[NSTAGE]);
   assign res.bwd = bwd_ff;

endmodule

@@ hdl/nau_smooth.sv @@
module nau_smooth (
   input  logic                    clock,
   input  logic                    en,
   input  nau_pkg::data_type       value_in,
   input  nau_pkg::data_type       upstream_grad,
   output nau_pkg::smooth_res_type res
);
   import nau_pkg::*;

   data_type v_ff      [1:5];
   data_type dy_ff     [1:7];
   sm_type   s_ff      [2:6];
   sm_type   tm_ff     [4:7];
   sm_type   vs_ff     [3:NSTAGE];
   acc_type  silu_b_ff [5:NSTAGE];
   sm_type   mish_f_ff [5:NSTAGE];
   acc_type  mish_b_ff [8:NSTAGE];
   data_type relu_f_ff [2:NSTAGE];
   data_type relu_b_ff [2:NSTAGE];
   sm_type   lpv_ff, sp_ff, sb_ff, mtt_ff, ma_ff, mb_ff;
   logic [15:0] mag_in;

   assign mag_in = v_ff[1][15] ? 16'(-v_ff[1]) : 16'(v_ff[1]);

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[1]  <= value_in;
         dy_ff[1] <= upstream_grad;
         for (int k = 2; k <= 5; k++) v_ff[k] <= v_ff[k-1];
         for (int k = 2; k <= 7; k++) dy_ff[k] <= dy_ff[k-1];
         for (int k = 3; k <= 6; k++) s_ff[k] <= s_ff[k-1];
         for (int k = 5; k <= 7; k++) tm_ff[k] <= tm_ff[k-1];
         for (int k = 4; k <= NSTAGE; k++) vs_ff[k] <= vs_ff[k-1];
         for (int k = 6; k <= NSTAGE; k++) silu_b_ff[k] <= silu_b_ff[k-1];
         for (int k = 6; k <= NSTAGE; k++) mish_f_ff[k] <= mish_f_ff[k-1];
         for (int k = 9; k <= NSTAGE; k++) mish_b_ff[k] <= mish_b_ff[k-1];
         for (int k = 3; k <= NSTAGE; k++) relu_f_ff[k] <= relu_f_ff[k-1];
         for (int k = 3; k <= NSTAGE; k++) relu_b_ff[k] <= relu_b_ff[k-1];
         s_ff[2]      <= sig(sg_type'(v_ff[1]));
         lpv_ff       <= lp(mag_in);
         relu_f_ff[2] <= (v_ff[1] > data_type'(0)) ? v_ff[1] : data_type'(0);
         relu_b_ff[2] <= (v_ff[1] > data_type'(0)) ? dy_ff[1] : data_type'(0);
         sp_ff        <= ((v_ff[2] > data_type'(0)) ? sm_type'(v_ff[2]) : sm_type'(0)) + lpv_ff;
         vs_ff[3]     <= sm_type'(mulq(opa_type'(v_ff[2]), s_ff[2]));
         tm_ff[4]     <= th(sp_ff);
         sb_ff        <= sm_type'(mulq(opa_type'(vs_ff[3]), sm_type'(Q_ONE) - s_ff[3]));
         silu_b_ff[5] <= mulq(opa_type'(dy_ff[4]), s_ff[4] + sb_ff);
         mtt_ff       <= sm_type'(mulq(opa_type'(tm_ff[4]), tm_ff[4]));
         mish_f_ff[5] <= sm_type'(mulq(opa_type'(v_ff[4]), tm_ff[4]));
         ma_ff        <= sm_type'(mulq(opa_type'(v_ff[5]), sm_type'(Q_ONE) - mtt_ff));
         mb_ff        <= sm_type'(mulq(opa_type'(ma_ff), s_ff[6]));
         mish_b_ff[8] <= mulq(opa_type'(dy_ff[7]), tm_ff[7] + mb_ff);
      end
   end

   assign res.relu_f = acc_type'(relu_f_ff[NSTAGE]);
   assign res.relu_b = acc_type'(relu_b_ff[NSTAGE]);
   assign res.silu_f = acc_type'(vs_ff[NSTAGE]);
   assign res.silu_b = silu_b_ff[NSTAGE];
   assign res.mish_f = acc_type'(mish_f_ff[NSTAGE]);
   assign res.mish_b = mish_b_ff[NSTAGE];

endmodule

@@ hdl/nau_swiglu.sv @@
module nau_swiglu (
   input  logic                    clock,
   input  logic                    en,
   input  nau_pkg::data_type       value_in,
   input  nau_pkg::data_type       gate_in,
   input  nau_pkg::data_type       upstream_grad,
   output nau_pkg::swiglu_res_type res
);
   import nau_pkg::*;

   data_type a_ff   [1:3];
   data_type b_ff   [1:2];
   data_type dy_ff  [1:3];
   sm_type   s_ff   [2:4];
   acc_type  rm_ff  [4:NSTAGE];
   acc_type  fwd_ff [4:NSTAGE];
   acc_type  gg_ff  [5:NSTAGE];
   sm_type   h_ff, x_ff;
   opa_type  dv_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[1]  <= value_in;
         b_ff[1]  <= gate_in;
         dy_ff[1] <= upstream_grad;
         for (int k = 2; k <= 3; k++) a_ff[k] <= a_ff[k-1];
         b_ff[2] <= b_ff[1];
         for (int k = 2; k <= 3; k++) dy_ff[k] <= dy_ff[k-1];
         for (int k = 3; k <= 4; k++) s_ff[k] <= s_ff[k-1];
         for (int k = 5; k <= NSTAGE; k++) rm_ff[k] <= rm_ff[k-1];
         for (int k = 5; k <= NSTAGE; k++) fwd_ff[k] <= fwd_ff[k-1];
         for (int k = 6; k <= NSTAGE; k++) gg_ff[k] <= gg_ff[k-1];
         s_ff[2]   <= sig(sg_type'(b_ff[1]));
         h_ff      <= sm_type'(mulq(opa_type'(b_ff[2]), s_ff[2]));
         rm_ff[4]  <= mulq(opa_type'(dy_ff[3]), h_ff);
         dv_ff     <= opa_type'(mulq(opa_type'(dy_ff[3]), sm_type'(a_ff[3])));
         x_ff      <= sm_type'(mulq(opa_type'(h_ff), sm_type'(Q_ONE) - s_ff[3]));
         fwd_ff[4] <= mulq(opa_type'(a_ff[3]), h_ff);
         gg_ff[5]  <= mulq(dv_ff, s_ff[4] + x_ff);
      end
   end

   assign res.fwd      = fwd_ff[NSTAGE];
   assign res.bwd_main = rm_ff[NSTAGE];
   assign res.bwd_gate = gg_ff[NSTAGE];

endmodule

@@ hdl/neural_activation_unit.sv @@
// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  one input word per element
// rsp_      out        rsp_tvalid/rsp_tready  one result word per element
// csr_      in         csr_valid/csr_ready    activation kind register
//
// A word enters in every cycle while the pipeline is not halted; the pipeline
// depth is set by the GELU backward chain of dependent fixed-point multiplies.
// Reset (synchronous, active high) empties the pipeline and selects GELU.
// The pipeline advances as one; a two-entry output buffer lets it take one
// more word while a result waits, and it halts only when both entries are full.
`include "neural_activation_unit_defines.svh"

module neural_activation_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: value_in [15:0], gate_in [31:16], upstream_grad [47:32]
   input  logic [47:0] req_tdata,
   // req_tuser: mode [0]
   input  logic        req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: result_main [15:0], gate_grad [31:16]
   output logic [31:0] rsp_tdata,
   // rsp_tuser: saturated [0]
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  csr_data,
   input  logic        csr_valid,
   output logic        csr_ready
);
   import nau_pkg::*;

   typedef struct packed {
      logic     flag;
      data_type val;
   } sat_type;

   // Clip a wide result to the word range and report whether it moved.
   function automatic sat_type clip(acc_type x);
      sat_type r;
      if (x > acc_type'(32'sh7fff)) begin
         r.flag = 1'b1;
         r.val  = data_type'(16'sh7fff);
      end else if (x < -acc_type'(32'sh8000)) begin
         r.flag = 1'b1;
         r.val  = data_type'(16'sh8000);
      end else begin
         r.flag = 1'b0;
         r.val  = data_type'(x);
      end
      return r;
   endfunction

   kind_type       kind_ff;
   logic           valid_ff [1:NSTAGE];
   ctl_type        ctl_ff   [1:NSTAGE];
   logic           en;
   gelu_res_type   gelu_res;
   smooth_res_type smooth_res;
   swiglu_res_type swiglu_res;
   acc_type        sel_r, sel_gg;
   sat_type        sat_r, sat_gg;
   logic [32:0]    push_word;
   logic [32:0]    out_ff, skid_ff;
   logic           out_valid_ff, skid_valid_ff;
   logic           push;

   // The pipeline moves whenever the output buffer has a free entry.
   assign en         = ~skid_valid_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_GELU;
      end else if (csr_valid && csr_data <= KIND_SWIGLU) begin
         kind_ff <= kind_type'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NSTAGE; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[1] <= req_tvalid;
         for (int k = 2; k <= NSTAGE; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff[1].kind <= kind_ff;
         ctl_ff[1].mode <= mode_type'(req_tuser);
         for (int k = 2; k <= NSTAGE; k++) ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   nau_gelu u_gelu (
      .clock         (clock),
      .en            (en),
      .value_in      (data_type'(req_tdata[15:0])),
      .upstream_grad (data_type'(req_tdata[47:32])),
      .res           (gelu_res)
   );

   nau_smooth u_smooth (
      .clock         (clock),
      .en            (en),
      .value_in      (data_type'(req_tdata[15:0])),
      .upstream_grad (data_type'(req_tdata[47:32])),
      .res           (smooth_res)
   );

   nau_swiglu u_swiglu (
      .clock         (clock),
      .en            (en),
      .value_in      (data_type'(req_tdata[15:0])),
      .gate_in       (data_type'(req_tdata[31:16])),
      .upstream_grad (data_type'(req_tdata[47:32])),
      .res           (swiglu_res)
   );

   // Every lane finishes at the last stage; the stored kind and mode of that
   // word pick the answer. The gate gradient is zero except for SwiGLU backward.
   always_comb begin
      sel_gg = '0;
      unique case (ctl_ff[NSTAGE].kind)
         KIND_GELU: begin
            sel_r = (ctl_ff[NSTAGE].mode == MODE_BWD) ? gelu_res.bwd : gelu_res.fwd;
         end
         KIND_RELU: begin
            sel_r = (ctl_ff[NSTAGE].mode == MODE_BWD) ? smooth_res.relu_b : smooth_res.relu_f;
         end
         KIND_SILU: begin
            sel_r = (ctl_ff[NSTAGE].mode == MODE_BWD) ? smooth_res.silu_b : smooth_res.silu_f;
         end
         KIND_MISH: begin
            sel_r = (ctl_ff[NSTAGE].mode == MODE_BWD) ? smooth_res.mish_b : smooth_res.mish_f;
         end
         KIND_SWIGLU: begin
            if (ctl_ff[NSTAGE].mode == MODE_BWD) begin
               sel_r  = swiglu_res.bwd_main;
               sel_gg = swiglu_res.bwd_gate;
            end else begin
               sel_r = swiglu_res.fwd;
            end
         end
         default: begin
            sel_r = '0;
         end
      endcase
      sat_r     = clip(sel_r);
      sat_gg    = clip(sel_gg);
      push_word = {sat_r.flag | sat_gg.flag, sat_gg.val, sat_r.val};
   end

   assign push = en & valid_ff[NSTAGE];

   // Output register plus skid entry: a word that arrives while the output
   // is stalled parks in the skid entry and moves up once the output drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff  <= skid_valid_ff | push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_tready) begin
         out_ff <= skid_valid_ff ? skid_ff : push_word;
      end else if (push) begin
         skid_ff <= push_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff[31:0];
   assign rsp_tuser  = out_ff[32];

   `NAU_CHECK(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff, "skid entry full while output empty")
   `NAU_CHECK(a_gate_zero, clock, reset, valid_ff[NSTAGE] && ctl_ff[NSTAGE].kind != KIND_SWIGLU, sel_gg == '0, "gate gradient nonzero outside SwiGLU")
   `NAU_CHECK(a_sat_at_bound, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[15:0] == 16'h7fff || rsp_tdata[15:0] == 16'h8000 || rsp_tdata[31:16] == 16'h7fff || rsp_tdata[31:16] == 16'h8000, "saturated word holds no clipped value")
   `NAU_CHECK(a_relu_fwd_pos, clock, reset, valid_ff[NSTAGE] && ctl_ff[NSTAGE].kind == KIND_RELU && ctl_ff[NSTAGE].mode == MODE_FWD, !sel_r[34], "ReLU forward result negative")
   `NAU_CHECK_NEXT(a_kind_written, clock, reset, csr_valid && csr_ready && csr_data <= KIND_SWIGLU, kind_ff == $past(csr_data), "legal kind write not taken")

endmodule

@@ verif/neural_activation_unit_test.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the activation unit. The expected word for every
// accepted input word is either typed in or computed by a fixed-point model of
// the five activations at the bench, and it is queued. The result stream is
// compared in order against that queue. A directed table comes first, and then
// random phases, each opened by its own kind write.
module neural_activation_unit_test;
   import nau_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_HOLD = 300;

   // A result word as the bench expects it.
   typedef struct {
      data_type main_val;
      data_type gate_val;
      logic     sat;
   } act_word_type;

   // One row of the directed table. known marks a row whose result is typed in.
   typedef struct {
      int kind;
      int mode;
      int v;
      int g;
      int dy;
      int known;
      int em;
      int eg;
      int es;
   } dir_row_type;

   localparam int NROWS = 23;
   dir_row_type dir_tab [NROWS] = '{
      '{0, 0,      0,      0,      0, 1,     0, 0, 0},
      '{0, 0,  32767,      0,      0, 0,     0, 0, 0},
      '{0, 0, -32768,      0,      0, 0,     0, 0, 0},
      '{0, 1,  32767,      0,  32767, 0,     0, 0, 0},
      '{0, 1, -32768,      0, -32768, 0,     0, 0, 0},
      '{0, 0,    256,  -1000,   4321, 0,     0, 0, 0},
      '{1, 0,  32767,      0,      0, 1, 32767, 0, 0},
      '{1, 0, -32768,      0,      0, 1,     0, 0, 0},
      '{1, 1,      1,      0, -32768, 1, -32768, 0, 0},
      '{1, 1,      0,      0,    100, 1,     0, 0, 0},
      '{1, 0,      0,  32767,  32767, 1,     0, 0, 0},
      '{2, 0,  32767,  12345,     -1, 0,     0, 0, 0},
      '{2, 1, -32768,      0,  32767, 0,     0, 0, 0},
      '{2, 1,    640,      0,   -900, 0,     0, 0, 0},
      '{3, 0,   2047,      0,      0, 0,     0, 0, 0},
      '{3, 0,  -2047,      0,      0, 0,     0, 0, 0},
      '{3, 1,  32767,      0,  32767, 0,     0, 0, 0},
      '{4, 0,  32767,  32767,      0, 1, 32767, 0, 1},
      '{4, 1, -32768, -32768,  32767, 0,     0, 0, 0},
      '{4, 1,    512,   -300,   -700, 0,     0, 0, 0},
      '{4, 0,      0,      0,      0, 1,     0, 0, 0},
      // Codes above four must leave the kind register alone.
      '{5, 0,    100,    200,      0, 0,     0, 0, 0},
      '{7, 1,   -333,    700,   1500, 0,     0, 0, 0}
   };

   logic        clock;
   logic        reset;
   logic [47:0] req_tdata;
   logic        req_tuser;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  csr_data;
   logic        csr_valid;
   logic        csr_ready;

   neural_activation_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   // The bench's own copy of the kind register.
   kind_type     cur_kind;
   act_word_type pending_words[$];
   int           words_sent;
   int           words_checked;
   int           sat_seen;
   int           mismatches;
   int           idle_cycles;
   int           hold_left;
   bit           hold_request;

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------
   // Fixed-point model of the activations, all in 64-bit integers.
   // ---------------------------------------------------------------------

   // Shift right with rounding half up; an arithmetic shift floors.
   function automatic longint round_shift(longint a, int s);
      return (a + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // Q8.8 product; the exact product is clipped to +-2^62 first.
   function automatic longint q_mul(longint a, longint b);
      longint ua;
      longint ub;
      longint p;
      longint lim;
      lim = longint'(1) <<< 62;
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      if (ua != 0 && ub > lim / ua) begin
         p = lim;
      end else begin
         p = ua * ub;
      end
      return round_shift(((a < 0) != (b < 0)) ? -p : p, FRAC_BITS);
   endfunction

   function automatic longint q16_scale(longint a, longint k);
      return round_shift(a * k, 16);
   endfunction

   // Piecewise sigmoid in four linear segments, mirrored for negative x.
   function automatic longint sigmoid_pw(longint x);
      longint a;
      longint y;
      a = (x < 0) ? -x : x;
      if (a >= 5 * Q_ONE) begin
         y = Q_ONE;
      end else if (a * 8 >= 19 * Q_ONE) begin
         y = round_shift(a + 27 * Q_ONE, 5);
      end else if (a >= Q_ONE) begin
         y = round_shift(a + 5 * Q_ONE, 3);
      end else begin
         y = round_shift(a + 2 * Q_ONE, 2);
      end
      return (x < 0) ? Q_ONE - y : y;
   endfunction

   function automatic longint tanh_pw(longint x);
      return 2 * sigmoid_pw(2 * x) - Q_ONE;
   endfunction

   // Softplus as max(x,0) plus an interpolated log1p(exp(-|x|)).
   function automatic longint softplus_pw(longint x);
      longint knots [9] = '{45426, 20530, 8318, 3184, 1189, 440, 162, 60, 0};
      longint a;
      longint i;
      longint f;
      longint tail;
      a = (x < 0) ? -x : x;
      i = a >>> FRAC_BITS;
      f = a & (Q_ONE - 1);
      tail = 0;
      if (i < 8) begin
         tail = round_shift(knots[i] * (Q_ONE - f) + knots[i + 1] * f, 16);
      end
      return ((x > 0) ? x : 0) + tail;
   endfunction

   function automatic data_type clip_q(longint v, ref logic sat);
      if (v > 32767) begin
         sat = 1'b1;
         return data_type'(16'sh7fff);
      end
      if (v < -32768) begin
         sat = 1'b1;
         return data_type'(16'sh8000);
      end
      return data_type'(v);
   endfunction

   function automatic act_word_type activate(kind_type kind, mode_type mode,
                                             data_type v_in, data_type g_in,
                                             data_type dy_in);
      act_word_type w;
      longint v;
      longint b;
      longint dy;
      longint vc;
      longint v2;
      longint u;
      longint t;
      longint s;
      longint h;
      longint du;
      longint d;
      longint r;
      longint gg;
      logic   sat;
      v = v_in;
      b = g_in;
      dy = dy_in;
      r = 0;
      gg = 0;
      sat = 1'b0;
      case (kind)
         KIND_GELU: begin
            // The cubic term uses the input clipped to +-8.
            vc = (v > 8 * Q_ONE) ? 8 * Q_ONE : ((v < -8 * Q_ONE) ? -8 * Q_ONE : v);
            v2 = q_mul(vc, vc);
            u = q16_scale(vc + q16_scale(q_mul(v2, vc), K_16), C_16);
            t = tanh_pw(u);
            if (mode == MODE_FWD) begin
               r = round_shift(q_mul(v, Q_ONE + t), 1);
            end else begin
               du = q16_scale(Q_ONE + q16_scale(v2, K3_16), C_16);
               d = round_shift(Q_ONE + t + q_mul(q_mul(vc, Q_ONE - q_mul(t, t)), du), 1);
               r = q_mul(dy, d);
            end
         end
         KIND_RELU: begin
            r = (v > 0) ? ((mode == MODE_BWD) ? dy : v) : 0;
         end
         KIND_SILU: begin
            s = sigmoid_pw(v);
            if (mode == MODE_FWD) begin
               r = q_mul(v, s);
            end else begin
               r = q_mul(dy, s + q_mul(q_mul(v, s), Q_ONE - s));
            end
         end
         KIND_MISH: begin
            t = tanh_pw(softplus_pw(v));
            if (mode == MODE_FWD) begin
               r = q_mul(v, t);
            end else begin
               r = q_mul(dy, t + q_mul(q_mul(v, Q_ONE - q_mul(t, t)), sigmoid_pw(v)));
            end
         end
         default: begin
            // SwiGLU: A times SiLU(B); backward also yields the gate gradient.
            s = sigmoid_pw(b);
            h = q_mul(b, s);
            if (mode == MODE_FWD) begin
               r = q_mul(v, h);
            end else begin
               r = q_mul(dy, h);
               gg = q_mul(q_mul(dy, v), s + q_mul(h, Q_ONE - s));
            end
         end
      endcase
      w.main_val = clip_q(r, sat);
      w.gate_val = clip_q(gg, sat);
      w.sat = sat;
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers.
   // ---------------------------------------------------------------------

   // Offers one word and waits for the handshake. When known is set, the
   // expected word is the one given; otherwise it comes from the model.
   task automatic send_word(mode_type mode, data_type v, data_type g, data_type dy,
                            bit known, act_word_type typed);
      act_word_type w;
      req_tdata <= {dy, g, v};
      req_tuser <= mode;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      w = known ? typed : activate(cur_kind, mode, v, g, dy);
      pending_words.push_back(w);
      words_sent++;
   endtask

   // The sender idles for a random gap now and then, ending a burst.
   task automatic maybe_gap();
      int gap;
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // The kind register is written only when the pipeline is empty.
   task automatic write_kind(logic [2:0] code);
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_data <= code;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      if (code <= KIND_SWIGLU) begin
         cur_kind = kind_type'(code);
      end
   endtask

   // Random Q8.8 value. Most values stay within +-8, where the approximations
   // change segment; the rest span the whole range.
   function automatic data_type rand_q();
      if ($urandom_range(0, 2) == 0) begin
         return data_type'($urandom);
      end
      return data_type'($signed($urandom_range(0, 4095)) - 2048);
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: it alternates between runs of steady readiness and random
   // stalls, and on request holds off for a long stretch so that the
   // pipeline fills and the input stalls.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (((words_checked / 64) % 2) == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   // ---------------------------------------------------------------------
   // Result checking, in order against the queue of expected words.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      act_word_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected result word %h sat %b", rsp_tdata, rsp_tuser);
            end
         end else begin
            w = pending_words.pop_front();
            if (rsp_tdata[15:0] !== w.main_val || rsp_tdata[31:16] !== w.gate_val ||
                rsp_tuser !== w.sat) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: word %0d expected main %h gate %h sat %b, got %h %h %b",
                           words_checked, w.main_val, w.gate_val, w.sat,
                           rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser);
               end
            end
            if (rsp_tuser === 1'b1) begin
               sat_seen++;
            end
         end
         words_checked++;
      end
   end

   // Watchdog: ends the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("** neural_activation_unit: FAILED **");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   initial begin
      act_word_type typed;
      int last_code;
      int phase;
      int n;
      logic [2:0] phase_kinds [10];
      clock = 1'b0;
      reset = 1'b1;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tvalid = 1'b0;
      csr_data = '0;
      csr_valid = 1'b0;
      rsp_tready = 1'b0;
      hold_left = 0;
      hold_request = 1'b0;
      cur_kind = KIND_GELU;
      words_sent = 0;
      words_checked = 0;
      sat_seen = 0;
      mismatches = 0;
      idle_cycles = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table. The first rows run on the reset value of the kind.
      last_code = 0;
      for (int i = 0; i < NROWS; i++) begin
         if (dir_tab[i].kind != last_code) begin
            write_kind(3'(dir_tab[i].kind));
            last_code = dir_tab[i].kind;
         end
         typed.main_val = data_type'(dir_tab[i].em);
         typed.gate_val = data_type'(dir_tab[i].eg);
         typed.sat = 1'(dir_tab[i].es);
         send_word(mode_type'(dir_tab[i].mode), data_type'(dir_tab[i].v),
                   data_type'(dir_tab[i].g), data_type'(dir_tab[i].dy),
                   dir_tab[i].known != 0, typed);
         maybe_gap();
      end

      // Random phases. Both ends of the kind range and an ignored code are
      // among the settings; the long hold-off falls in the third phase.
      phase_kinds = '{KIND_GELU, KIND_SWIGLU, KIND_RELU, KIND_MISH, 3'd6,
                      KIND_SILU, KIND_SWIGLU, KIND_GELU, KIND_MISH, KIND_SILU};
      for (phase = 0; phase < 10; phase++) begin
         write_kind(phase_kinds[phase]);
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         n = $urandom_range(30, 50);
         for (int k = 0; k < n; k++) begin
            send_word(mode_type'($urandom_range(0, 1)), rand_q(), rand_q(), rand_q(),
                      1'b0, typed);
            if (phase % 3 != 0) begin
               maybe_gap();
            end
         end
      end
      req_tvalid <= 1'b0;

      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d words over GELU, ReLU, SiLU, Mish and SwiGLU,", words_sent);
      $display("both modes, ignored kind codes and %0d saturated results.", sat_seen);
      if (mismatches == 0) begin
         $display("** neural_activation_unit: PASSED **");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("** neural_activation_unit: FAILED **");
      end
      $finish;
   end

endmodule
